[rtl/mtes_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mtes_pkg
// Shared types and constants of the multi-timer expiry scanner: field widths,
// command and result codes, the queued command entry and the back-end states.
// ----------------------------------------------------------------------------
package mtes_pkg;

   localparam int NUM_SLOTS_DEFAULT = 16;

   localparam int CMD_W  = 2;
   localparam int SLOT_W = 4;
   localparam int TIME_W = 32;
   localparam int TAG_W  = 16;
   localparam int KIND_W = 2;

   localparam logic [TIME_W-1:0] NEXT_DELAY_RESET = 32'd9999999;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;

   localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIRE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_CLEAR,
      OP_NOP,
      OP_CHECK
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [SLOT_W-1:0]   slot;
      logic [TIME_W-1:0]   stamp;
      logic [TIME_W-1:0]   period;
      logic [TAG_W-1:0]    tag;
   } cmd_entry_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_SUMMARY
   } back_state_type;

endpackage
`default_nettype wire

[rtl/multi_timer_expiry_scanner.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// multi_timer_expiry_scanner
// Table of NUM_SLOTS timers with add, remove and check commands. A check
// reports every expired slot in ascending slot order, reloads periodic
// timers, frees one-shot timers and ends with the delay to the nearest expiry.
// ----------------------------------------------------------------------------
// Add, remove and unused commands give one acknowledgement each. A check
// holds the slot engine for a scan of every slot, paced by the slot table's
// single read port, which reads one slot per cycle; the scan pauses while a
// fire result waits in the output register. A two-entry command queue lets
// requests be accepted while the engine is busy. The max_next_delay register
// is written through the csr_ channel, which is always ready; write it only
// while the block is idle.
// ----------------------------------------------------------------------------
module multi_timer_expiry_scanner #(
   parameter int NUM_SLOTS = mtes_pkg::NUM_SLOTS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [mtes_pkg::TIME_W-1:0]  csr_max_next_delay,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [mtes_pkg::CMD_W-1:0]   req_command,
   input  wire logic [mtes_pkg::SLOT_W-1:0]  req_slot,
   input  wire logic [mtes_pkg::TIME_W-1:0]  req_expire_time,
   input  wire logic [mtes_pkg::TIME_W-1:0]  req_period,
   input  wire logic [mtes_pkg::TAG_W-1:0]   req_tag,
   input  wire logic [mtes_pkg::TIME_W-1:0]  req_now_time,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [mtes_pkg::KIND_W-1:0]       rsp_kind,
   output logic [mtes_pkg::SLOT_W-1:0]       rsp_fired_slot,
   output logic [mtes_pkg::TAG_W-1:0]        rsp_fired_tag,
   output logic [mtes_pkg::TIME_W-1:0]       rsp_next_delay,
   output logic                              rsp_last
);
   import mtes_pkg::*;

   logic          q_full;
   logic          q_push;
   logic          q_pop;
   logic          q_valid;
   cmd_entry_type q_entry;
   cmd_entry_type q_head;

   assign csr_ready = 1'b1;

   mtes_front #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_slot        (req_slot),
      .req_expire_time (req_expire_time),
      .req_period      (req_period),
      .req_tag         (req_tag),
      .req_now_time    (req_now_time),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_entry         (q_entry)
   );

   mtes_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_entry (q_entry),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_valid (q_valid),
      .q_head  (q_head)
   );

   mtes_back #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_max_next_delay (csr_max_next_delay),
      .q_valid            (q_valid),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_fired_slot     (rsp_fired_slot),
      .rsp_fired_tag      (rsp_fired_tag),
      .rsp_next_delay     (rsp_next_delay),
      .rsp_last           (rsp_last)
   );

endmodule
`default_nettype wire

[rtl/mtes_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mtes_front
// Accepts request transfers, decodes the command and the slot range check,
// and pushes one classified entry into the command queue.
// ----------------------------------------------------------------------------
module mtes_front #(
   parameter int NUM_SLOTS = mtes_pkg::NUM_SLOTS_DEFAULT
) (
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [mtes_pkg::CMD_W-1:0]   req_command,
   input  wire logic [mtes_pkg::SLOT_W-1:0]  req_slot,
   input  wire logic [mtes_pkg::TIME_W-1:0]  req_expire_time,
   input  wire logic [mtes_pkg::TIME_W-1:0]  req_period,
   input  wire logic [mtes_pkg::TAG_W-1:0]   req_tag,
   input  wire logic [mtes_pkg::TIME_W-1:0]  req_now_time,
   input  wire logic                         q_full,
   output logic                              q_push,
   output mtes_pkg::cmd_entry_type           q_entry
);
   import mtes_pkg::*;

   localparam int RANGE_W = 9;

   logic in_range;

   assign in_range  = RANGE_W'(req_slot) < RANGE_W'(NUM_SLOTS);
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_entry.slot   = req_slot;
      q_entry.period = req_period;
      q_entry.tag    = req_tag;
      q_entry.stamp  = req_expire_time;
      unique case (req_command)
         CMD_ADD: begin
            q_entry.op = in_range ? OP_WRITE : OP_NOP;
         end
         CMD_REMOVE: begin
            q_entry.op = in_range ? OP_CLEAR : OP_NOP;
         end
         CMD_CHECK: begin
            q_entry.op    = OP_CHECK;
            q_entry.stamp = req_now_time;
         end
         default: begin
            q_entry.op = OP_NOP;
         end
      endcase
   end

endmodule
`default_nettype wire

[rtl/mtes_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mtes_queue
// Short command queue between the front end and the slot engine, so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module mtes_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_push,
   input  mtes_pkg::cmd_entry_type       q_entry,
   output logic                          q_full,
   input  wire logic                     q_pop,
   output logic                          q_valid,
   output mtes_pkg::cmd_entry_type       q_head
);
   import mtes_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_entry_type     entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign q_full  = count_ff == CNT_W'(QUEUE_DEPTH);
   assign q_valid = count_ff != '0;
   assign q_head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (q_push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !q_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         entries_ff[wr_ptr_ff] <= q_entry;
      end
   end

endmodule
`default_nettype wire

[rtl/mtes_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mtes_back
// Slot engine: holds the timer table, applies add and remove, runs the
// three-stage check scan (read, fire test and reload, delay minimum) and
// drives the registered result channel.
// ----------------------------------------------------------------------------
module mtes_back #(
   parameter int NUM_SLOTS = mtes_pkg::NUM_SLOTS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   input  wire logic [mtes_pkg::TIME_W-1:0]  csr_max_next_delay,
   input  wire logic                         q_valid,
   input  mtes_pkg::cmd_entry_type           q_head,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [mtes_pkg::KIND_W-1:0]       rsp_kind,
   output logic [mtes_pkg::SLOT_W-1:0]       rsp_fired_slot,
   output logic [mtes_pkg::TAG_W-1:0]        rsp_fired_tag,
   output logic [mtes_pkg::TIME_W-1:0]       rsp_next_delay,
   output logic                              rsp_last
);
   import mtes_pkg::*;

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);
   localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

   // slot table
   logic [TIME_W-1:0] mem_expiry [NUM_SLOTS];
   logic [TIME_W-1:0] mem_period [NUM_SLOTS];
   logic [TAG_W-1:0]  mem_tag    [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] slot_valid_ff, slot_valid_in;

   back_state_type state_ff, state_in;

   logic [TIME_W-1:0] max_delay_ff, max_delay_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] next_ff, next_in;
   logic [CNT_W-1:0]  rd_cnt_ff, rd_cnt_in;

   // read stage
   logic              s2_vld_ff, s2_vld_in;
   logic              s2_live_ff;
   logic [IDX_W-1:0]  s2_idx_ff;
   logic [TIME_W-1:0] s2_exp_ff;
   logic [TIME_W-1:0] s2_per_ff;
   logic [TAG_W-1:0]  s2_tag_ff;

   // delay stage
   logic              s3_vld_ff, s3_vld_in;
   logic [TIME_W-1:0] s3_exp_ff, s3_exp_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [TAG_W-1:0]  rsp_tag_ff, rsp_tag_in;
   logic [TIME_W-1:0] rsp_delay_ff, rsp_delay_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic              load_rsp;
   logic              issue_done;
   logic              rd_en;
   logic              fire;
   logic              adv2;
   logic              one_shot;
   logic [TIME_W-1:0] reload_exp;
   logic [TIME_W-1:0] delay;
   logic [IDX_W-1:0]  rd_idx;
   logic [EXT_W-1:0]  head_ext;
   logic [IDX_W-1:0]  head_idx;
   logic [EXT_W-1:0]  fire_ext;
   logic              do_write;
   logic              do_reload;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign issue_done = rd_cnt_ff == CNT_W'(NUM_SLOTS);
   assign rd_idx     = rd_cnt_ff[IDX_W-1:0];
   assign head_ext   = EXT_W'(q_head.slot);
   assign head_idx   = head_ext[IDX_W-1:0];
   assign fire_ext   = EXT_W'(s2_idx_ff);

   assign fire       = s2_vld_ff && s2_live_ff && (now_ff >= s2_exp_ff);
   assign one_shot   = s2_per_ff == '0;
   assign reload_exp = s2_exp_ff + s2_per_ff;
   assign adv2       = !fire || out_free;
   assign delay      = s3_exp_ff - now_ff;

   assign max_delay_in = csr_valid ? csr_max_next_delay : max_delay_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_pop && q_head.op == OP_CHECK) begin
               state_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (issue_done && !s2_vld_ff && !s3_vld_ff) begin
               state_in = BK_SUMMARY;
            end
         end
         BK_SUMMARY: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // outputs and datapath control
   always_comb begin
      q_pop         = 1'b0;
      rd_en         = 1'b0;
      load_rsp      = 1'b0;
      do_write      = 1'b0;
      do_reload     = 1'b0;
      slot_valid_in = slot_valid_ff;
      now_in        = now_ff;
      next_in       = next_ff;
      rd_cnt_in     = rd_cnt_ff;
      s2_vld_in     = s2_vld_ff;
      s3_vld_in     = 1'b0;
      s3_exp_in     = s3_exp_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_delay_in  = rsp_delay_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         BK_IDLE: begin
            q_pop = q_valid && (q_head.op == OP_CHECK || out_free);
            if (q_pop) begin
               unique case (q_head.op)
                  OP_CHECK: begin
                     now_in    = q_head.stamp;
                     next_in   = max_delay_ff;
                     rd_cnt_in = '0;
                  end
                  OP_WRITE: begin
                     do_write                = 1'b1;
                     slot_valid_in[head_idx] = 1'b1;
                  end
                  OP_CLEAR: begin
                     slot_valid_in[head_idx] = 1'b0;
                  end
                  default: begin
                  end
               endcase
               if (q_head.op != OP_CHECK) begin
                  load_rsp     = 1'b1;
                  rsp_kind_in  = KIND_ACK;
                  rsp_slot_in  = '0;
                  rsp_tag_in   = '0;
                  rsp_delay_in = '0;
                  rsp_last_in  = 1'b1;
               end
            end
         end
         BK_SCAN: begin
            rd_en = adv2 && !issue_done;
            if (rd_en) begin
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
            if (adv2) begin
               s2_vld_in = rd_en;
               s3_vld_in = s2_vld_ff && s2_live_ff && !(fire && one_shot);
               s3_exp_in = fire ? reload_exp : s2_exp_ff;
            end
            if (fire && out_free) begin
               load_rsp     = 1'b1;
               rsp_kind_in  = KIND_FIRE;
               rsp_slot_in  = fire_ext[SLOT_W-1:0];
               rsp_tag_in   = s2_tag_ff;
               rsp_delay_in = '0;
               rsp_last_in  = 1'b0;
               if (one_shot) begin
                  slot_valid_in[s2_idx_ff] = 1'b0;
               end else begin
                  do_reload = 1'b1;
               end
            end
            if (s3_vld_ff && delay < next_ff) begin
               next_in = delay;
            end
         end
         BK_SUMMARY: begin
            if (out_free) begin
               load_rsp     = 1'b1;
               rsp_kind_in  = KIND_SUMMARY;
               rsp_slot_in  = '0;
               rsp_tag_in   = '0;
               rsp_delay_in = next_ff;
               rsp_last_in  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         slot_valid_ff <= '0;
         max_delay_ff  <= NEXT_DELAY_RESET;
         s2_vld_ff     <= 1'b0;
         s3_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rd_cnt_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         max_delay_ff  <= max_delay_in;
         s2_vld_ff     <= s2_vld_in;
         s3_vld_ff     <= s3_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_cnt_ff     <= rd_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff    <= now_in;
      next_ff   <= next_in;
      s3_exp_ff <= s3_exp_in;
      if (load_rsp) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_slot_ff  <= rsp_slot_in;
         rsp_tag_ff   <= rsp_tag_in;
         rsp_delay_ff <= rsp_delay_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   // table write port
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem_expiry[head_idx] <= q_head.stamp;
         mem_period[head_idx] <= q_head.period;
         mem_tag[head_idx]    <= q_head.tag;
      end else if (do_reload) begin
         mem_expiry[s2_idx_ff] <= reload_exp;
      end
   end

   // table read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         s2_exp_ff  <= mem_expiry[rd_idx];
         s2_per_ff  <= mem_period[rd_idx];
         s2_tag_ff  <= mem_tag[rd_idx];
         s2_live_ff <= slot_valid_ff[rd_idx];
         s2_idx_ff  <= rd_idx;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_fired_slot = rsp_slot_ff;
   assign rsp_fired_tag  = rsp_tag_ff;
   assign rsp_next_delay = rsp_delay_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
`default_nettype wire
